>>> rtl/mrsp_pkg.sv
// mrsp_pkg: types and byte codes shared by the running status parser
// no dependencies; used by the parser core, the top level and the checker

package mrsp_pkg;

  // system real-time codes
  localparam logic [7:0] RT_FIRST    = 8'hF8;
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONTINUE = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;

  // system common codes that carry data
  localparam logic [7:0] SC_MTC_QUARTER = 8'hF1;
  localparam logic [7:0] SC_SONG_POS    = 8'hF2;
  localparam logic [7:0] SC_SONG_SEL    = 8'hF3;

  // high nibbles
  localparam logic [3:0] HI_SYSTEM      = 4'hF;
  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;

  localparam logic [7:0] NO_STATUS = 8'h00;

  typedef enum logic [2:0] {
    EV_CHANNEL  = 3'd0,
    EV_CLOCK    = 3'd1,
    EV_START    = 3'd2,
    EV_STOP     = 3'd3,
    EV_CONTINUE = 3'd4,
    EV_OTHER    = 3'd5
  } mrsp_kind_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [4:0] channel_number;
  } mrsp_result_t;

  typedef struct packed {
    logic         hit;
    mrsp_result_t result;
  } mrsp_decode_t;

endpackage

>>> rtl/mrsp_if.sv
// mrsp_byte_if and mrsp_event_if: valid/ready channels for received bytes and events
// no dependencies

interface mrsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrsp_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] status_byte;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic [4:0] channel_number;

  modport source (output valid, output event_kind, output status_byte, output first_data,
                  output second_data, output channel_number, input ready);
  modport sink   (input valid, input event_kind, input status_byte, input first_data,
                  input second_data, input channel_number, output ready);
endinterface

>>> rtl/midi_running_status_parser_top.sv
// midi_running_status_parser_top: input word register, parser core and event output register
// depends on mrsp_pkg, mrsp_if (mrsp_byte_if, mrsp_event_if) and mrsp_parse

// Takes one received MIDI byte per word on in_ch and gives zero or one event word on out_ch.
// Real-time bytes F8..FF give an event at once (kind 1 clock, 2 start, 3 stop, 4 continue,
// 5 other) without disturbing a message in progress. Channel status bytes set running status;
// each complete channel message gives kind 0 with status, both data bytes (second is 0 for
// program change and channel pressure) and channel 1..16. F0, F4..F7 clear the parser; F1..F3
// collect their data and drop it, cancelling running status. Each byte waits in the input
// register and its event is registered into the output register as the byte moves on; a byte is
// accepted in every cycle, throughput one word per clock, as long as out_ch keeps taking events.

module midi_running_status_parser_top (
  input  logic                clk,
  input  logic                rst,
  mrsp_byte_if.sink           in_ch,
  mrsp_event_if.source        out_ch
);

  // input word register
  logic       in_valid;
  logic [7:0] in_byte;

  // output event register
  logic                   out_valid;
  mrsp_pkg::mrsp_result_t out_res;

  mrsp_pkg::mrsp_decode_t dec;
  logic                   out_free;
  logic                   advance;

  // byte in the input register moves on when it makes no event or the output slot frees
  assign out_free    = !out_valid || out_ch.ready;
  assign advance     = in_valid && (!dec.hit || out_free);
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.rx_byte;
    end
  end

  // parser state and decode
  mrsp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .byte_in (in_byte),
    .update  (advance),
    .dec     (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && dec.hit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec.hit) begin
      out_res <= dec.result;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.event_kind     = out_res.event_kind;
  assign out_ch.status_byte    = out_res.status_byte;
  assign out_ch.first_data     = out_res.first_data;
  assign out_ch.second_data    = out_res.second_data;
  assign out_ch.channel_number = out_res.channel_number;

endmodule

>>> rtl/mrsp_parse.sv
// mrsp_parse: parser state registers and the single-pass byte decode
// depends on mrsp_pkg

module mrsp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            byte_in,
  input  logic                  update,
  output mrsp_pkg::mrsp_decode_t dec
);

  logic [7:0] running_status, running_status_next;
  logic [1:0] expected_count, expected_count_next;
  logic [1:0] received_count, received_count_next;
  logic [6:0] held_data, held_data_next;
  logic       sc_mark, sc_mark_next;
  logic [1:0] received_inc;
  logic [1:0] need;

  always_comb begin
    running_status_next = running_status;
    expected_count_next = expected_count;
    received_count_next = received_count;
    held_data_next      = held_data;
    sc_mark_next        = sc_mark;
    dec                 = '0;
    need                = 2'd2;
    received_inc        = received_count + 2'd1;

    if (byte_in >= mrsp_pkg::RT_FIRST) begin
      // real-time: event only, state untouched
      dec.hit                = 1'b1;
      dec.result.status_byte = byte_in;
      unique case (byte_in)
        mrsp_pkg::RT_CLOCK:    dec.result.event_kind = mrsp_pkg::EV_CLOCK;
        mrsp_pkg::RT_START:    dec.result.event_kind = mrsp_pkg::EV_START;
        mrsp_pkg::RT_STOP:     dec.result.event_kind = mrsp_pkg::EV_STOP;
        mrsp_pkg::RT_CONTINUE: dec.result.event_kind = mrsp_pkg::EV_CONTINUE;
        default:               dec.result.event_kind = mrsp_pkg::EV_OTHER;
      endcase
    end else if (byte_in[7]) begin
      if (byte_in[7:4] == mrsp_pkg::HI_SYSTEM) begin
        unique case (byte_in) inside
          mrsp_pkg::SC_MTC_QUARTER, mrsp_pkg::SC_SONG_SEL: begin
            running_status_next = byte_in;
            expected_count_next = 2'd1;
            received_count_next = 2'd0;
            sc_mark_next        = 1'b1;
          end
          mrsp_pkg::SC_SONG_POS: begin
            running_status_next = byte_in;
            expected_count_next = 2'd2;
            received_count_next = 2'd0;
            sc_mark_next        = 1'b1;
          end
          default: begin
            // sysex, tune request and undefined codes clear running status, counts and mark
            running_status_next = mrsp_pkg::NO_STATUS;
            expected_count_next = 2'd0;
            received_count_next = 2'd0;
            sc_mark_next        = 1'b0;
          end
        endcase
      end else begin
        if (byte_in[7:4] == mrsp_pkg::HI_PROG_CHANGE ||
            byte_in[7:4] == mrsp_pkg::HI_CHAN_PRESS) begin
          need = 2'd1;
        end
        running_status_next = byte_in;
        expected_count_next = need;
        received_count_next = 2'd0;
        sc_mark_next        = 1'b0;
      end
    end else if (running_status != mrsp_pkg::NO_STATUS && expected_count != 2'd0) begin
      if (received_count == 2'd0) begin
        held_data_next = byte_in[6:0];
      end
      if (received_inc < expected_count) begin
        received_count_next = received_inc;
      end else begin
        received_count_next = 2'd0;
        if (sc_mark) begin
          // system common complete: dropped, running status cancelled
          running_status_next = mrsp_pkg::NO_STATUS;
          expected_count_next = 2'd0;
          sc_mark_next        = 1'b0;
        end else begin
          dec.hit                   = 1'b1;
          dec.result.event_kind     = mrsp_pkg::EV_CHANNEL;
          dec.result.status_byte    = running_status;
          dec.result.first_data     = (expected_count == 2'd2) ? held_data : byte_in[6:0];
          dec.result.second_data    = (expected_count == 2'd2) ? byte_in[6:0] : 7'd0;
          dec.result.channel_number = {1'b0, running_status[3:0]} + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= mrsp_pkg::NO_STATUS;
      expected_count <= 2'd0;
      received_count <= 2'd0;
      sc_mark        <= 1'b0;
    end else if (update) begin
      running_status <= running_status_next;
      expected_count <= expected_count_next;
      received_count <= received_count_next;
      sc_mark        <= sc_mark_next;
    end
  end

  // held data byte needs no reset: only read after being written
  always_ff @(posedge clk) begin
    if (update) begin
      held_data <= held_data_next;
    end
  end

endmodule

>>> rtl/mrsp_checker.sv
// mrsp_checker: port-level assertions on the event channel, bound to the top level
// depends on mrsp_pkg and midi_running_status_parser_top

module mrsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_kind,
  input logic [7:0] status_byte,
  input logic [6:0] first_data,
  input logic [6:0] second_data,
  input logic [4:0] channel_number
);

  // stalled event stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  // stalled event payload holds
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status_byte) && $stable(event_kind) &&
      $stable(first_data) && $stable(second_data) && $stable(channel_number))
    else $error("event payload changed while stalled");

  // channel message carries a channel status and its matching channel number
  a_channel_msg: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == mrsp_pkg::EV_CHANNEL |->
      status_byte[7] && status_byte[7:4] != mrsp_pkg::HI_SYSTEM &&
      channel_number == {1'b0, status_byte[3:0]} + 5'd1)
    else $error("malformed channel message");

  // real-time events echo a real-time byte with zero data
  a_realtime: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != mrsp_pkg::EV_CHANNEL |->
      status_byte >= mrsp_pkg::RT_FIRST && first_data == 7'd0 &&
      second_data == 7'd0 && channel_number == 5'd0)
    else $error("malformed real-time event");

  // event kind agrees with the real-time byte for clock, start and stop
  a_rt_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_byte >= mrsp_pkg::RT_FIRST |->
      (event_kind == mrsp_pkg::EV_CLOCK) == (status_byte == mrsp_pkg::RT_CLOCK) &&
      (event_kind == mrsp_pkg::EV_START) == (status_byte == mrsp_pkg::RT_START) &&
      (event_kind == mrsp_pkg::EV_STOP) == (status_byte == mrsp_pkg::RT_STOP))
    else $error("real-time kind mismatch");

endmodule

bind midi_running_status_parser_top mrsp_checker u_mrsp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .event_kind     (out_ch.event_kind),
  .status_byte    (out_ch.status_byte),
  .first_data     (out_ch.first_data),
  .second_data    (out_ch.second_data),
  .channel_number (out_ch.channel_number)
);
